// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an active-low reset that disables it
`define PPD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the usual clock and reset port names
`define PPD_ASSERT(label, prop, msg) `PPD_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ----- hw/rtl/ppd_pkg.sv -----
// types, constants and width helpers for the point to plane distance core
package ppd_pkg;

    // result width and saturation bounds
    localparam int DIST_W = 18;
    localparam int KW = 18;
    localparam logic [KW-1:0] DIST_POS_MAX = 18'd131071;
    localparam logic [KW-1:0] DIST_NEG_MAG = 18'd131072;

    // flags that ride along with the root search
    typedef struct packed {
        logic neg;
        logic degen;
    } t_tag;

    // widths as functions of the coordinate width
    function automatic int d_w(input int cw);
        return cw + 1;
    endfunction

    function automatic int nn_w(input int cw);
        return 4 * cw + 6;
    endfunction

    function automatic int dot_w(input int cw);
        return 3 * cw + 6;
    endfunction

    function automatic int sq_w(input int cw);
        return 2 * dot_w(cw);
    endfunction

    function automatic int cmp_w(input int cw);
        return (nn_w(cw) + 2 * KW > sq_w(cw)) ? nn_w(cw) + 2 * KW : sq_w(cw);
    endfunction

endpackage

// ----- hw/rtl/ppd_geom.sv -----
// edge vectors, normal, squared normal length and dot product, five stages
module ppd_geom #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [COORD_WIDTH-1:0]          i_q_x,
    input  logic signed [COORD_WIDTH-1:0]          i_q_y,
    input  logic signed [COORD_WIDTH-1:0]          i_q_z,
    input  logic signed [COORD_WIDTH-1:0]          i_r_x,
    input  logic signed [COORD_WIDTH-1:0]          i_r_y,
    input  logic signed [COORD_WIDTH-1:0]          i_r_z,
    input  logic signed [COORD_WIDTH-1:0]          i_s_x,
    input  logic signed [COORD_WIDTH-1:0]          i_s_y,
    input  logic signed [COORD_WIDTH-1:0]          i_s_z,
    input  logic signed [COORD_WIDTH-1:0]          i_p_x,
    input  logic signed [COORD_WIDTH-1:0]          i_p_y,
    input  logic signed [COORD_WIDTH-1:0]          i_p_z,
    input  logic                                   i_ready,
    output logic                                   o_valid,
    output logic [ppd_pkg::nn_w(COORD_WIDTH)-1:0]  o_nn,
    output logic signed [ppd_pkg::dot_w(COORD_WIDTH)-1:0] o_dot
);

    localparam int D = ppd_pkg::d_w(COORD_WIDTH);
    localparam int PW = 2 * D;
    localparam int NW = 2 * D + 1;
    localparam int SW = 2 * NW;
    localparam int DPW = D + NW;
    localparam int NN_W = ppd_pkg::nn_w(COORD_WIDTH);
    localparam int DOT_W = ppd_pkg::dot_w(COORD_WIDTH);

    logic [4:0] r_v;
    logic [4:0] w_en;

    assign w_en[4] = !r_v[4] || i_ready;
    assign w_en[3] = !r_v[3] || w_en[4];
    assign w_en[2] = !r_v[2] || w_en[3];
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_ready = w_en[0];
    assign o_valid = r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
            if (w_en[4]) r_v[4] <= r_v[3];
        end
    end

    // stage 1: differences against q
    logic signed [D-1:0] r_e1 [3];
    logic signed [D-1:0] r_e2 [3];
    logic signed [D-1:0] r_d1 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_e1[0] <= D'(i_r_x) - D'(i_q_x);
            r_e1[1] <= D'(i_r_y) - D'(i_q_y);
            r_e1[2] <= D'(i_r_z) - D'(i_q_z);
            r_e2[0] <= D'(i_s_x) - D'(i_q_x);
            r_e2[1] <= D'(i_s_y) - D'(i_q_y);
            r_e2[2] <= D'(i_s_z) - D'(i_q_z);
            r_d1[0] <= D'(i_p_x) - D'(i_q_x);
            r_d1[1] <= D'(i_p_y) - D'(i_q_y);
            r_d1[2] <= D'(i_p_z) - D'(i_q_z);
        end
    end

    // stage 2: cross product terms
    logic signed [PW-1:0] r_c [6];
    logic signed [D-1:0]  r_d2 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_c[0] <= r_e1[1] * r_e2[2];
            r_c[1] <= r_e1[2] * r_e2[1];
            r_c[2] <= r_e1[2] * r_e2[0];
            r_c[3] <= r_e1[0] * r_e2[2];
            r_c[4] <= r_e1[0] * r_e2[1];
            r_c[5] <= r_e1[1] * r_e2[0];
            r_d2 <= r_d1;
        end
    end

    // stage 3: normal
    logic signed [NW-1:0] r_n [3];
    logic signed [D-1:0]  r_d3 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_n[0] <= NW'(r_c[0]) - NW'(r_c[1]);
            r_n[1] <= NW'(r_c[2]) - NW'(r_c[3]);
            r_n[2] <= NW'(r_c[4]) - NW'(r_c[5]);
            r_d3 <= r_d2;
        end
    end

    // stage 4: squares of the normal and dot terms
    logic signed [SW-1:0]  r_sq [3];
    logic signed [DPW-1:0] r_pr [3];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_n[i] * r_n[i];
                r_pr[i] <= r_d3[i] * r_n[i];
            end
        end
    end

    // stage 5: sums
    logic [NN_W-1:0]         r_nn;
    logic signed [DOT_W-1:0] r_dot;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_nn  <= NN_W'(r_sq[0]) + NN_W'(r_sq[1]) + NN_W'(r_sq[2]);
            r_dot <= DOT_W'(r_pr[0]) + DOT_W'(r_pr[1]) + DOT_W'(r_pr[2]);
        end
    end

    assign o_nn  = r_nn;
    assign o_dot = r_dot;

endmodule

// ----- hw/rtl/ppd_square.sv -----
// magnitude of the dot product and its square from half-width products, two stages
module ppd_square #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [ppd_pkg::nn_w(COORD_WIDTH)-1:0]         i_nn,
    input  logic signed [ppd_pkg::dot_w(COORD_WIDTH)-1:0] i_dot,
    input  logic                                          i_ready,
    output logic                                          o_valid,
    output logic [ppd_pkg::nn_w(COORD_WIDTH)-1:0]         o_nn,
    output logic [ppd_pkg::sq_w(COORD_WIDTH)-1:0]         o_dsq,
    output ppd_pkg::t_tag                                 o_tag
);

    localparam int NN_W = ppd_pkg::nn_w(COORD_WIDTH);
    localparam int MAG_W = ppd_pkg::dot_w(COORD_WIDTH);
    localparam int SQ_W = ppd_pkg::sq_w(COORD_WIDTH);
    localparam int LO_W = MAG_W / 2;
    localparam int HI_W = MAG_W - LO_W;

    logic [1:0] r_v;
    logic [1:0] w_en;

    assign w_en[1] = !r_v[1] || i_ready;
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_ready = w_en[0];
    assign o_valid = r_v[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
        end
    end

    logic             w_neg;
    logic [MAG_W-1:0] w_mag;

    assign w_neg = i_dot[MAG_W-1];
    assign w_mag = w_neg ? (~MAG_W'(i_dot) + MAG_W'(1)) : MAG_W'(i_dot);

    // stage 1: partial products of the magnitude split in halves
    logic [2*HI_W-1:0]    r_hh;
    logic [HI_W+LO_W-1:0] r_hl;
    logic [2*LO_W-1:0]    r_ll;
    logic [NN_W-1:0]      r_nn0;
    ppd_pkg::t_tag        r_tag0;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_hh  <= w_mag[MAG_W-1:LO_W] * w_mag[MAG_W-1:LO_W];
            r_hl  <= w_mag[MAG_W-1:LO_W] * w_mag[LO_W-1:0];
            r_ll  <= w_mag[LO_W-1:0] * w_mag[LO_W-1:0];
            r_nn0 <= i_nn;
            r_tag0.neg   <= w_neg;
            r_tag0.degen <= (i_nn == '0);
        end
    end

    // stage 2: recombine
    logic [SQ_W-1:0] r_dsq;
    logic [NN_W-1:0] r_nn1;
    ppd_pkg::t_tag   r_tag1;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_dsq  <= (SQ_W'(r_hh) << (2 * LO_W)) + (SQ_W'(r_hl) << (LO_W + 1))
                      + SQ_W'(r_ll);
            r_nn1  <= r_nn0;
            r_tag1 <= r_tag0;
        end
    end

    assign o_nn  = r_nn1;
    assign o_dsq = r_dsq;
    assign o_tag = r_tag1;

endmodule

// ----- hw/rtl/ppd_search.sv -----
// quotient by the root of the normal length, one result bit per stage
module ppd_search #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [ppd_pkg::nn_w(COORD_WIDTH)-1:0] i_nn,
    input  logic [ppd_pkg::sq_w(COORD_WIDTH)-1:0] i_dsq,
    input  ppd_pkg::t_tag                         i_tag,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic [ppd_pkg::KW-1:0]                o_mag,
    output ppd_pkg::t_tag                         o_tag
);

    localparam int KW = ppd_pkg::KW;
    localparam int NN_W = ppd_pkg::nn_w(COORD_WIDTH);
    localparam int SQ_W = ppd_pkg::sq_w(COORD_WIDTH);
    localparam int CMP_W = ppd_pkg::cmp_w(COORD_WIDTH);

    // per stage: r_t = k*k*nn, r_a = k*nn, r_k = bits decided so far
    logic [CMP_W-1:0] r_t   [KW];
    logic [CMP_W-1:0] r_a   [KW];
    logic [KW-1:0]    r_k   [KW];
    logic [NN_W-1:0]  r_nn  [KW];
    logic [SQ_W-1:0]  r_dsq [KW];
    ppd_pkg::t_tag    r_tag [KW];
    logic [KW-1:0]    r_v;
    logic [KW-1:0]    w_en;

    for (genvar j = 0; j < KW; j++) begin : g_stage
        localparam int B = KW - 1 - j;

        logic [CMP_W-1:0] w_t;
        logic [CMP_W-1:0] w_a;
        logic [KW-1:0]    w_k;
        logic [NN_W-1:0]  w_nn;
        logic [SQ_W-1:0]  w_dsq;
        ppd_pkg::t_tag    w_tag;
        logic             w_v;
        logic [CMP_W-1:0] w_trial;

        if (j == 0) begin : g_first
            assign w_t   = '0;
            assign w_a   = '0;
            assign w_k   = '0;
            assign w_nn  = i_nn;
            assign w_dsq = i_dsq;
            assign w_tag = i_tag;
            assign w_v   = i_valid;
        end else begin : g_next
            assign w_t   = r_t[j-1];
            assign w_a   = r_a[j-1];
            assign w_k   = r_k[j-1];
            assign w_nn  = r_nn[j-1];
            assign w_dsq = r_dsq[j-1];
            assign w_tag = r_tag[j-1];
            assign w_v   = r_v[j-1];
        end

        if (j == KW - 1) begin : g_last_en
            assign w_en[j] = !r_v[j] || i_ready;
        end else begin : g_mid_en
            assign w_en[j] = !r_v[j] || w_en[j+1];
        end

        // (k + 2^b)^2 nn = k^2 nn + 2^(b+1) k nn + 2^(2b) nn
        assign w_trial = w_t + (w_a << (B + 1)) + (CMP_W'(w_nn) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_en[j]) begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j]) begin
                if (w_trial <= CMP_W'(w_dsq)) begin
                    r_t[j] <= w_trial;
                    r_a[j] <= w_a + (CMP_W'(w_nn) << B);
                    r_k[j] <= w_k | (KW'(1) << B);
                end else begin
                    r_t[j] <= w_t;
                    r_a[j] <= w_a;
                    r_k[j] <= w_k;
                end
                r_nn[j]  <= w_nn;
                r_dsq[j] <= w_dsq;
                r_tag[j] <= w_tag;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[KW-1];
    assign o_mag   = r_k[KW-1];
    assign o_tag   = r_tag[KW-1];

endmodule

// ----- hw/rtl/point_plane_distance_core.sv -----
// top level of the point to plane distance core
//
// One input word carries triangle vertices q, r, s and a query point p, each
// coordinate a signed fixed-point number. One output word gives the signed
// distance of p from the triangle's plane, truncated toward zero and
// saturated to 18 bits, plus a flag for a zero normal (distance then 0).
// The fractional scaling cancels, so output and input share one scaling.
// Both channels move a word when valid is high and stall is low.
// Throughput is one word per cycle while the receiver does not stall; the path
// from input to output register is five geometry stages, two squaring stages,
// one stage per result bit of the root search (18) and the output register.
// Each stage holds a valid bit; a stage takes new data when it is empty or
// the stage after it moves, so bubbles close up while the receiver stalls.
// Input stall rises only when every stage and the output register are full
// and the receiver stalls.
// Reset clears all valid bits; nothing else needs clearing.
module point_plane_distance_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_q_x,
    input  logic signed [COORD_WIDTH-1:0]         i_q_y,
    input  logic signed [COORD_WIDTH-1:0]         i_q_z,
    input  logic signed [COORD_WIDTH-1:0]         i_r_x,
    input  logic signed [COORD_WIDTH-1:0]         i_r_y,
    input  logic signed [COORD_WIDTH-1:0]         i_r_z,
    input  logic signed [COORD_WIDTH-1:0]         i_s_x,
    input  logic signed [COORD_WIDTH-1:0]         i_s_y,
    input  logic signed [COORD_WIDTH-1:0]         i_s_z,
    input  logic signed [COORD_WIDTH-1:0]         i_p_x,
    input  logic signed [COORD_WIDTH-1:0]         i_p_y,
    input  logic signed [COORD_WIDTH-1:0]         i_p_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [ppd_pkg::DIST_W-1:0]     o_signed_distance,
    output logic                                  o_degenerate
);

    localparam int NN_W = ppd_pkg::nn_w(COORD_WIDTH);
    localparam int DOT_W = ppd_pkg::dot_w(COORD_WIDTH);
    localparam int SQ_W = ppd_pkg::sq_w(COORD_WIDTH);
    localparam int KW = ppd_pkg::KW;
    localparam int DIST_W = ppd_pkg::DIST_W;

    logic                    w_geom_ready;
    logic                    w_geom_valid;
    logic [NN_W-1:0]         w_geom_nn;
    logic signed [DOT_W-1:0] w_geom_dot;
    logic                    w_sq_ready;
    logic                    w_sq_valid;
    logic [NN_W-1:0]         w_sq_nn;
    logic [SQ_W-1:0]         w_sq_dsq;
    ppd_pkg::t_tag           w_sq_tag;
    logic                    w_srch_ready;
    logic                    w_srch_valid;
    logic [KW-1:0]           w_srch_mag;
    ppd_pkg::t_tag           w_srch_tag;
    logic                    w_out_en;

    ppd_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_geom_ready),
        .i_q_x   (i_q_x),
        .i_q_y   (i_q_y),
        .i_q_z   (i_q_z),
        .i_r_x   (i_r_x),
        .i_r_y   (i_r_y),
        .i_r_z   (i_r_z),
        .i_s_x   (i_s_x),
        .i_s_y   (i_s_y),
        .i_s_z   (i_s_z),
        .i_p_x   (i_p_x),
        .i_p_y   (i_p_y),
        .i_p_z   (i_p_z),
        .i_ready (w_sq_ready),
        .o_valid (w_geom_valid),
        .o_nn    (w_geom_nn),
        .o_dot   (w_geom_dot)
    );

    ppd_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geom_valid),
        .o_ready (w_sq_ready),
        .i_nn    (w_geom_nn),
        .i_dot   (w_geom_dot),
        .i_ready (w_srch_ready),
        .o_valid (w_sq_valid),
        .o_nn    (w_sq_nn),
        .o_dsq   (w_sq_dsq),
        .o_tag   (w_sq_tag)
    );

    ppd_search #(.COORD_WIDTH(COORD_WIDTH)) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_srch_ready),
        .i_nn    (w_sq_nn),
        .i_dsq   (w_sq_dsq),
        .i_tag   (w_sq_tag),
        .i_ready (w_out_en),
        .o_valid (w_srch_valid),
        .o_mag   (w_srch_mag),
        .o_tag   (w_srch_tag)
    );

    assign o_stall  = !w_geom_ready;
    assign w_out_en = !o_valid || !i_stall;

    // clamp the magnitude to the negative bound, then positive results to the positive bound
    logic [KW-1:0]     w_mag;
    logic [DIST_W-1:0] n_dist;

    always_comb begin
        w_mag = (w_srch_mag > ppd_pkg::DIST_NEG_MAG) ? ppd_pkg::DIST_NEG_MAG : w_srch_mag;
        priority if (w_srch_tag.degen) begin
            n_dist = '0;
        end else if (w_srch_tag.neg) begin
            n_dist = DIST_W'(~w_mag + KW'(1));
        end else if (w_mag > ppd_pkg::DIST_POS_MAX) begin
            n_dist = DIST_W'(ppd_pkg::DIST_POS_MAX);
        end else begin
            n_dist = DIST_W'(w_mag);
        end
    end

    logic              r_out_valid;
    logic [DIST_W-1:0] r_dist;
    logic              r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= w_srch_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_dist  <= n_dist;
            r_degen <= w_srch_tag.degen;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_signed_distance = r_dist;
    assign o_degenerate      = r_degen;

endmodule

// ----- hw/rtl/ppd_checker.sv -----
// port-level checks for the point to plane distance core, bound to the top level
`include "assert_macros.svh"

module ppd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_stall,
    input logic                                o_valid,
    input logic                                o_stall,
    input logic signed [ppd_pkg::DIST_W-1:0]   o_signed_distance,
    input logic                                o_degenerate
);

    // a stalled output word holds
    `PPD_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_signed_distance) && $stable(o_degenerate), "output word changed while stalled")

    // a zero normal always reports zero distance
    `PPD_ASSERT(a_degen_zero, o_valid && o_degenerate |-> o_signed_distance == '0, "degenerate word with nonzero distance")

    // input back-pressure only while a finished word is held by the receiver
    `PPD_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled without a stalled output word")

endmodule

bind point_plane_distance_core ppd_checker u_ppd_checker (.*);
